@@ hw/rtl/slx_pkg.sv @@
`timescale 1ns / 1ps

package slx_pkg;

    localparam int LINE_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int MAX_RECS        = 3;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_COMMENT,
        MODE_NUMBER,
        MODE_STRING,
        MODE_STR_DONE,
        MODE_IDENT,
        MODE_HALT
    } mode_t;

    typedef enum logic [1:0] {
        REC_CHAR = 2'd0,
        REC_END  = 2'd1,
        REC_ERR  = 2'd2
    } rec_kind_t;

    typedef enum logic [1:0] {
        TOK_NUM   = 2'd0,
        TOK_STR   = 2'd1,
        TOK_PUNC  = 2'd2,
        TOK_IDENT = 2'd3
    } tok_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_TRAIL_SEP  = 2'd1,
        ERR_OPEN_STR   = 2'd2,
        ERR_STRAY_SEP  = 2'd3
    } err_code_t;

    typedef struct packed {
        logic [7:0] char_value;
        logic       end_of_text;
    } src_t;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [1:0]  token_kind;
        logic [7:0]  token_char;
        logic [15:0] line_number;
        logic [1:0]  error_code;
        logic        last_of_run;
    } res_t;

    typedef struct packed {
        logic [1:0]           count;
        res_t [MAX_RECS-1:0]  recs;
    } bundle_t;

    function automatic res_t make_rec(
        input rec_kind_t   kind,
        input tok_kind_t   tok,
        input logic [7:0]  ch,
        input logic [15:0] line,
        input err_code_t   err
    );
        res_t r;
        r.record_kind = kind;
        r.token_kind  = tok;
        r.token_char  = ch;
        r.line_number = line;
        r.error_code  = err;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

@@ hw/rtl/source_text_lexer_core.sv @@
// A record reaches res_data through the bundle queue, the current-bundle register and the output register.
// Throughput: one byte per cycle while records average one per byte or fewer; each byte
// yields 0 to 3 records, drained one per cycle by the output stage while res_stall is
// low, through a bundle queue (QUEUE_DEPTH entries); a full queue stalls the source.
// Reset (rst_n, async, active low): lexer idle, line count 1, queue and output empty,
// live flag (live_reg) cleared.
`timescale 1ns / 1ps

module source_text_lexer_core
    import slx_pkg::*;
#(
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_write,
    input  logic cfg_data,
    input  logic src_valid,
    output logic src_stall,
    input  src_t src_data,
    output logic res_valid,
    input  logic res_stall,
    output res_t res_data
);

    logic    accept;
    logic    push, pop, q_full, q_empty;
    bundle_t push_data, pop_data;

    assign src_stall = q_full;
    assign accept    = src_valid && !q_full;

    slx_front #(
        .LINE_BITS (LINE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .src_data  (src_data),
        .push      (push),
        .push_data (push_data)
    );

    slx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    slx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (pop_data),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule

@@ hw/rtl/slx_front.sv @@
`timescale 1ns / 1ps

module slx_front
    import slx_pkg::*;
#(
    parameter int LINE_BITS = LINE_BITS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cfg_write,
    input  logic    cfg_data,
    input  logic    accept,
    input  src_t    src_data,
    output logic    push,
    output bundle_t push_data
);

    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

    mode_t                mode_reg, mode_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    logic                 bs_reg, bs_next;
    logic                 sep_reg, sep_next;
    logic                 start_reg, start_next;
    logic                 live_reg;

    logic [7:0] c;
    logic       eot;
    logic       is_digit, is_letter, is_alnum, is_sep, is_quote, is_punc, is_op;
    logic       is_hash, is_nl, is_bslash;
    logic       idle_entry;

    logic [LINE_BITS-1:0]  line_inc, line_sel, line_less;
    logic [LINE_BITS+15:0] cur_ext, less_ext;
    logic [15:0]           line_cur16, line_less16;

    res_t [MAX_RECS-1:0] recs;
    logic [1:0]          n;

    assign c   = src_data.char_value;
    assign eot = src_data.end_of_text;

    assign is_digit  = (c >= "0") && (c <= "9");
    assign is_letter = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    assign is_alnum  = is_digit || is_letter;
    assign is_sep    = (c == ".") || (c == ",");
    assign is_quote  = (c == 8'h22) || (c == 8'h27);
    assign is_punc   = (c == "-") || (c == "(") || (c == ")");
    assign is_op     = (c == "+") || (c == "*") || (c == "/") || (c == "<")
                    || (c == "=") || (c == ">") || (c == "^");
    assign is_hash   = (c == "#");
    assign is_nl     = (c == 8'h0a);
    assign is_bslash = (c == 8'h5c);

    assign line_inc = (!start_reg && is_nl && (line_reg != LINE_MAX))
                    ? line_reg + LINE_ONE : line_reg;
    assign line_sel  = eot ? line_reg : line_inc;
    assign line_less = (line_sel != '0) ? line_sel - LINE_ONE : '0;
    assign cur_ext     = {16'b0, line_sel};
    assign less_ext    = {16'b0, line_less};
    assign line_cur16  = cur_ext[15:0];
    assign line_less16 = less_ext[15:0];

    always_comb
    begin
        case (mode_reg)
            MODE_IDLE:     idle_entry = 1'b1;
            MODE_STR_DONE: idle_entry = 1'b1;
            MODE_NUMBER:   idle_entry = !(is_digit || is_sep) && !sep_reg;
            MODE_IDENT:    idle_entry = !is_alnum;
            default:       idle_entry = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        mode_next  = mode_reg;
        line_next  = line_reg;
        bs_next    = bs_reg;
        sep_next   = sep_reg;
        start_next = start_reg;
        if (eot)
        begin
            mode_next  = MODE_IDLE;
            line_next  = LINE_ONE;
            bs_next    = 1'b0;
            sep_next   = 1'b0;
            start_next = 1'b1;
        end
        else
        begin
            start_next = 1'b0;
            line_next  = line_inc;
            case (mode_reg)
                MODE_COMMENT:
                begin
                    if (is_nl)
                        mode_next = MODE_IDLE;
                end
                MODE_NUMBER:
                begin
                    if (is_digit || is_sep)
                        sep_next = is_sep;
                    else if (sep_reg)
                        mode_next = MODE_HALT;
                end
                MODE_STRING:
                begin
                    if (is_quote && !bs_reg)
                        mode_next = MODE_STR_DONE;
                    else
                        bs_next = is_bslash;
                end
                default: ;
            endcase
            if (idle_entry)
            begin
                if (is_hash)
                    mode_next = MODE_COMMENT;
                else if (is_digit)
                begin
                    sep_next  = 1'b0;
                    mode_next = MODE_NUMBER;
                end
                else if (is_quote)
                begin
                    bs_next   = 1'b0;
                    mode_next = MODE_STRING;
                end
                else if (is_punc)
                    mode_next = MODE_IDLE;
                else if (is_sep)
                    mode_next = MODE_HALT;
                else if (is_letter || is_op)
                    mode_next = MODE_IDENT;
                else
                    mode_next = MODE_IDLE;
            end
        end
    end

    // records caused by this transaction
    always_comb
    begin
        recs = '0;
        n    = 2'd0;
        if (eot)
        begin
            case (mode_reg)
                MODE_NUMBER:
                begin
                    if (sep_reg)
                        recs[0] = make_rec(REC_ERR, TOK_NUM, 8'd0, line_less16, ERR_TRAIL_SEP);
                    else
                        recs[0] = make_rec(REC_END, TOK_NUM, 8'd0, line_cur16, ERR_NONE);
                    n = 2'd1;
                end
                MODE_IDENT:
                begin
                    recs[0] = make_rec(REC_END, TOK_IDENT, 8'd0, line_cur16, ERR_NONE);
                    n = 2'd1;
                end
                MODE_STRING:
                begin
                    recs[0] = make_rec(REC_ERR, TOK_NUM, 8'd0,
                                       live_reg ? line_cur16 : line_less16, ERR_OPEN_STR);
                    n = 2'd1;
                end
                MODE_STR_DONE:
                begin
                    recs[0] = make_rec(REC_END, TOK_STR, 8'd0, line_cur16, ERR_NONE);
                    n = 2'd1;
                end
                default: ;
            endcase
        end
        else
        begin
            case (mode_reg)
                MODE_NUMBER:
                begin
                    if (is_digit || is_sep)
                        recs[n] = make_rec(REC_CHAR, TOK_NUM, c, 16'd0, ERR_NONE);
                    else if (sep_reg)
                        recs[n] = make_rec(REC_ERR, TOK_NUM, 8'd0, line_less16, ERR_TRAIL_SEP);
                    else
                        recs[n] = make_rec(REC_END, TOK_NUM, 8'd0, line_cur16, ERR_NONE);
                    n = n + 2'd1;
                end
                MODE_STRING:
                begin
                    if (!(is_quote && !bs_reg))
                    begin
                        recs[n] = make_rec(REC_CHAR, TOK_STR, c, 16'd0, ERR_NONE);
                        n = n + 2'd1;
                    end
                end
                MODE_STR_DONE:
                begin
                    recs[n] = make_rec(REC_END, TOK_STR, 8'd0, line_cur16, ERR_NONE);
                    n = n + 2'd1;
                end
                MODE_IDENT:
                begin
                    if (is_alnum)
                        recs[n] = make_rec(REC_CHAR, TOK_IDENT, c, 16'd0, ERR_NONE);
                    else
                        recs[n] = make_rec(REC_END, TOK_IDENT, 8'd0, line_cur16, ERR_NONE);
                    n = n + 2'd1;
                end
                default: ;
            endcase
            if (idle_entry)
            begin
                if (is_hash || is_quote)
                begin
                end
                else if (is_digit)
                begin
                    recs[n] = make_rec(REC_CHAR, TOK_NUM, c, 16'd0, ERR_NONE);
                    n = n + 2'd1;
                end
                else if (is_punc)
                begin
                    recs[n] = make_rec(REC_CHAR, TOK_PUNC, c, 16'd0, ERR_NONE);
                    n = n + 2'd1;
                    recs[n] = make_rec(REC_END, TOK_PUNC, 8'd0, line_cur16, ERR_NONE);
                    n = n + 2'd1;
                end
                else if (is_sep)
                begin
                    recs[n] = make_rec(REC_ERR, TOK_NUM, 8'd0, line_less16, ERR_STRAY_SEP);
                    n = n + 2'd1;
                end
                else if (is_letter || is_op)
                begin
                    recs[n] = make_rec(REC_CHAR, TOK_IDENT, c, 16'd0, ERR_NONE);
                    n = n + 2'd1;
                end
            end
        end
        if (n != 2'd0)
            recs[n - 2'd1].last_of_run = 1'b1;
    end

    assign push            = accept && (n != 2'd0);
    assign push_data.count = n;
    assign push_data.recs  = recs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            line_reg  <= LINE_ONE;
            bs_reg    <= 1'b0;
            sep_reg   <= 1'b0;
            start_reg <= 1'b1;
            live_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg  <= mode_next;
                line_reg  <= line_next;
                bs_reg    <= bs_next;
                sep_reg   <= sep_next;
                start_reg <= start_next;
            end
            if (cfg_write)
                live_reg <= cfg_data;
        end
    end

endmodule

@@ hw/rtl/slx_queue.sv @@
`timescale 1ns / 1ps

module slx_queue
    import slx_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t push_data,
    input  logic    pop,
    output bundle_t pop_data,
    output logic    full,
    output logic    empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    bundle_t [DEPTH-1:0] mem_reg;
    logic [PTR_W-1:0]    wr_reg, wr_next;
    logic [PTR_W-1:0]    rd_reg, rd_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
            wr_next = (wr_reg == PTR_LAST) ? '0 : wr_reg + PTR_W'(1);
        if (do_pop)
            rd_next = (rd_reg == PTR_LAST) ? '0 : rd_reg + PTR_W'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ hw/rtl/slx_back.sv @@
`timescale 1ns / 1ps

module slx_back
    import slx_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_empty,
    input  bundle_t q_data,
    output logic    pop,
    output logic    res_valid,
    input  logic    res_stall,
    output res_t    res_data
);

    bundle_t    cur_reg, cur_next;
    logic [1:0] idx_reg, idx_next;
    logic       busy_reg, busy_next;
    res_t       out_reg, out_next;
    logic       out_valid_reg, out_valid_next;

    logic       load, take, last_rec;

    assign load     = !out_valid_reg || !res_stall;
    assign take     = load && busy_reg;
    assign last_rec = (idx_reg == (cur_reg.count - 2'd1));
    assign pop      = (!busy_reg || (take && last_rec)) && !q_empty;

    always_comb
    begin
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        busy_next      = busy_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_next       = cur_reg.recs[idx_reg];
            out_valid_next = 1'b1;
        end
        else if (load)
            out_valid_next = 1'b0;
        if (pop)
        begin
            cur_next  = q_data;
            idx_next  = 2'd0;
            busy_next = 1'b1;
        end
        else if (take)
        begin
            if (last_rec)
                busy_next = 1'b0;
            else
                idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

endmodule
